@@ design/msb_first_bit_packer_core_assert.svh @@
// Assertion macros for the MSB-first bit packer checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// Hold a signal while its beat is stalled.
`define MFBP_ASSERT_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error("mfbp: stalled beat changed");

// Implication checked at every rising clock edge outside reset.
`define MFBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("mfbp: output beat check failed");

`endif

@@ design/mfbp_pkg.sv @@
// Shared types and constants for the MSB-first bit packer.
// No dependencies.
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int unsigned MAX_BYTES      = 65536;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned VAL_W          = 64;
  localparam int unsigned BC_W           = 7;
  localparam int unsigned CNT_W          = 17;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned NBYTES_MAX     = VAL_W / BYTE_W;
  localparam int unsigned NB_W           = $clog2(NBYTES_MAX + 1);
  localparam int unsigned IDX_W          = $clog2(NBYTES_MAX);
  localparam int unsigned PCNT_W         = 3;
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam int unsigned PTR_W          = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W         = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned S_TDATA_W      = 72;
  localparam int unsigned M_TDATA_W      = 32;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic [NB_W-1:0]  nbytes;
    logic             fin;
    logic             has;
  } mfbp_entry_t;

endpackage

@@ design/mfbp_front.sv @@
// Front end: accepts input beats, merges held bits with new field bits
// and queues whole-byte work entries. Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mfbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            full_i,
  output logic                            push_o,
  output mfbp_pkg::mfbp_entry_t           entry_o
);
  import mfbp_pkg::*;

  localparam int unsigned WIDE_W = VAL_W + BYTE_W;

  logic [BYTE_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;

  logic [VAL_W-1:0]  value;
  logic [BC_W-1:0]   bc, n, shl;
  logic [VAL_W-1:0]  vin;
  logic [WIDE_W-1:0] wide;
  logic [BC_W:0]     total;
  logic [NB_W-1:0]   nb;
  logic [BYTE_W-1:0] byt [NBYTES_MAX+1];
  logic              accept;

  assign value  = s_axis_tdata[VAL_W-1:0];
  assign bc     = s_axis_tdata[VAL_W +: BC_W];
  assign s_axis_tready = !full_i;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    n     = (bc > BC_W'(MAX_FIELD_BITS)) ? BC_W'(MAX_FIELD_BITS) : bc;
    shl   = BC_W'(VAL_W) - n;
    vin   = value << shl;
    wide  = ({vin, {BYTE_W{1'b0}}} >> pcnt_q) | {pend_q, {VAL_W{1'b0}}};
    total = {{(BC_W+1-PCNT_W){1'b0}}, pcnt_q} + {1'b0, n};
    nb    = total[PCNT_W +: NB_W];
    for (int i = 0; i <= NBYTES_MAX; i++) begin
      byt[i] = wide[WIDE_W-1-BYTE_W*i -: BYTE_W];
    end
  end

  always_comb begin
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    push_o  = 1'b0;
    entry_o = '{data: wide[WIDE_W-1:BYTE_W], nbytes: nb, fin: 1'b0, has: 1'b1};
    if (accept) begin
      if (s_axis_tuser == KIND_FINISH) begin
        push_o  = 1'b1;
        entry_o = '{data: {pend_q, {(VAL_W-BYTE_W){1'b0}}}, nbytes: NB_W'(1),
                    fin: 1'b1, has: (pcnt_q != '0)};
        pend_d  = '0;
        pcnt_d  = '0;
      end else begin
        push_o = (nb != '0);
        pend_d = byt[nb];
        pcnt_d = total[PCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

@@ design/mfbp_fifo.sv @@
// Short work queue between front and back end.
// Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mfbp_pkg::mfbp_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output mfbp_pkg::mfbp_entry_t head_o
);
  import mfbp_pkg::*;

  mfbp_entry_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(FIFO_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rp_q];

  always_comb begin
    wp_d   = push_i ? PTR_W'(wp_q + 1'b1) : wp_q;
    rp_d   = pop_i  ? PTR_W'(rp_q + 1'b1) : rp_q;
    fill_d = fill_q + FILL_W'(push_i) - FILL_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

endmodule

@@ design/mfbp_back.sv @@
// Back end: splits queued entries into output byte beats, keeps the
// saturating byte count and drives the output register. Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  mfbp_pkg::mfbp_entry_t           head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mfbp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import mfbp_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_nxt;
  logic              vld_q, vld_d;
  logic [BYTE_W-1:0] byte_q, byte_d, cur_byte;
  logic [CNT_W-1:0]  bcnt_q, bcnt_d;
  logic              has_q, has_d, last_q, last_d;
  logic              load, is_last;

  assign load    = !vld_q || m_axis_tready;
  assign is_last = ({1'b0, idx_q} == NB_W'(head_i.nbytes - 1'b1));
  assign cur_byte = head_i.data[VAL_W-1-BYTE_W*idx_q -: BYTE_W];

  always_comb begin
    cnt_nxt = cnt_q;
    if (head_i.has && (cnt_q < CNT_W'(MAX_BYTES))) begin
      cnt_nxt = cnt_q + 1'b1;
    end
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    bcnt_d = bcnt_q;
    has_d  = has_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        byte_d = cur_byte;
        bcnt_d = cnt_nxt;
        has_d  = head_i.has;
        last_d = is_last;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
          cnt_d = head_i.fin ? '0 : cnt_nxt;
        end else begin
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bcnt_q <= bcnt_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W-CNT_W-BYTE_W){1'b0}}, bcnt_q, byte_q};
  assign m_axis_tuser  = has_q;
  assign m_axis_tlast  = last_q;

endmodule

@@ design/msb_first_bit_packer_core.sv @@
// The first output beat of an item passes through the work queue and then the output register.
// One output byte per cycle while the receiver is ready, set by the single-byte output lane;
// an append gives one beat per byte it completes (0 to 8), a finish gives one beat.
// Input beats are taken every cycle while the two-entry work queue has room.
// Reset clears held bits, byte count, queue and output valid.
`timescale 1ns / 1ps

module msb_first_bit_packer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mfbp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value[63:0], bit_count[70:64]
  input  logic                            s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mfbp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0], byte_count[24:8]
  output logic                            m_axis_tuser,  // has_byte
  output logic                            m_axis_tlast   // last
);
  import mfbp_pkg::*;

  mfbp_entry_t entry, head;
  logic        push, pop, full, empty;

  mfbp_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  mfbp_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  mfbp_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

@@ design/mfbp_checker.sv @@
// Port-level checker for the MSB-first bit packer, bound to the top level.
// Depends on mfbp_pkg and msb_first_bit_packer_core_assert.svh.
`timescale 1ns / 1ps
`include "msb_first_bit_packer_core_assert.svh"

module mfbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mfbp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);
  import mfbp_pkg::*;

  logic [BYTE_W-1:0] obyte;
  logic [CNT_W-1:0]  ocnt;

  assign obyte = m_axis_tdata[BYTE_W-1:0];
  assign ocnt  = m_axis_tdata[BYTE_W +: CNT_W];

  `MFBP_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `MFBP_ASSERT_IMP(a_empty_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  `MFBP_ASSERT_IMP(a_empty_zero, m_axis_tvalid && !m_axis_tuser, obyte == '0)
  `MFBP_ASSERT_IMP(a_count_live, m_axis_tvalid && m_axis_tuser, ocnt != '0)

endmodule

bind msb_first_bit_packer_core mfbp_checker u_mfbp_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for msb_first_bit_packer_core: streams append and finish beats
// through bursty input and stalling output, predicts every packed byte beat and checks it.
// Depends on mfbp_pkg and the msb_first_bit_packer_core RTL.
`timescale 1ns / 1ps

module tb_top;
  import mfbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_FIELDS = 400;
  localparam int unsigned HOLD_START  = 400;
  localparam int unsigned HOLD_END    = 700;
  localparam int unsigned DRAIN_WAIT  = 16;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
    logic [BC_W-1:0]  bit_count;
  } field_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } byte_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // value[63:0], bit_count[70:64]
  logic                 s_axis_tuser = 1'b0;  // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // out_byte[7:0], byte_count[24:8]
  logic                 m_axis_tuser;  // has_byte
  logic                 m_axis_tlast;

  field_t     fields_pending[$];
  byte_beat_t byte_beats_due[$];

  logic [BYTE_W-1:0] held_bits = '0;
  int                held_cnt = 0;
  int                bytes_written = 0;

  int          total_fields = -1;
  int          fields_taken = 0;
  int          errors = 0;
  logic        field_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int unsigned rx_cyc = 0;
  int          rx_mode = 0;
  int unsigned cycles = 0;

  msb_first_bit_packer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic count_byte();
    if (bytes_written < MAX_BYTES) bytes_written++;
  endtask

  task automatic pack_field(input logic kind, input logic [VAL_W-1:0] val,
                            input logic [BC_W-1:0] bc);
    byte_beat_t b;
    int         n;
    int         i;
    int         k;
    k = 0;
    if (kind == KIND_FINISH) begin
      b.has_byte = (held_cnt != 0);
      b.out_byte = '0;
      if (held_cnt != 0) begin
        count_byte();
        b.out_byte = held_bits << (BYTE_W - held_cnt);
      end
      b.byte_count = bytes_written[CNT_W-1:0];
      b.last = 1'b1;
      byte_beats_due.push_back(b);
      held_bits = '0;
      held_cnt = 0;
      bytes_written = 0;
    end else begin
      n = (bc > MAX_FIELD_BITS) ? MAX_FIELD_BITS : bc;
      for (i = n - 1; i >= 0; i--) begin
        held_bits = {held_bits[BYTE_W-2:0], val[i]};
        held_cnt++;
        if (held_cnt == BYTE_W) begin
          count_byte();
          b.out_byte = held_bits;
          b.has_byte = 1'b1;
          b.byte_count = bytes_written[CNT_W-1:0];
          b.last = 1'b0;
          byte_beats_due.push_back(b);
          k++;
          held_bits = '0;
          held_cnt = 0;
        end
      end
      if (k > 0) begin
        b = byte_beats_due.pop_back();
        b.last = 1'b1;
        byte_beats_due.push_back(b);
      end
    end
  endtask

  task automatic add_field(input logic kind, input logic [VAL_W-1:0] val,
                           input logic [BC_W-1:0] bc);
    field_t f;
    f.kind = kind;
    f.value = val;
    f.bit_count = bc;
    fields_pending.push_back(f);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Driver: advance on acceptance, idle in gaps between bursts
  always @(negedge clk_i) begin
    field_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || field_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (fields_pending.size() > 0) begin
        nxt = fields_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, nxt.bit_count, nxt.value};
        s_axis_tuser <= nxt.kind;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a changing pattern, hold off for a long stretch once
  always @(negedge clk_i) begin
    rx_cyc++;
    if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_cyc >= HOLD_START && rx_cyc < HOLD_END) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= rx_cyc[0];
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk_i) begin
    byte_beat_t want;
    byte_beat_t got;
    if (rst_ni) begin
      field_taken = s_axis_tvalid && s_axis_tready;
      if (field_taken) begin
        pack_field(s_axis_tuser, s_axis_tdata[VAL_W-1:0], s_axis_tdata[VAL_W+BC_W-1:VAL_W]);
        fields_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte = m_axis_tdata[BYTE_W-1:0];
        got.byte_count = m_axis_tdata[BYTE_W+CNT_W-1:BYTE_W];
        got.has_byte = m_axis_tuser;
        got.last = m_axis_tlast;
        if (byte_beats_due.size() == 0) begin
          $display("%0t: unexpected beat: byte %h has %b count %0d last %b", $time,
                   got.out_byte, got.has_byte, got.byte_count, got.last);
          errors++;
        end else begin
          want = byte_beats_due.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
            errors++;
          end
          if (got.has_byte !== want.has_byte) begin
            $display("%0t: has_byte expected %b actual %b", $time, want.has_byte, got.has_byte);
            errors++;
          end
          if (got.byte_count !== want.byte_count) begin
            $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                     got.byte_count);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still due", $time, byte_beats_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          made;
    int          run_len;
    int          j;
    int unsigned r;
    logic [BC_W-1:0] bc;

    // directed: extremes, alignment, oversize counts, both kinds of finish
    add_field(KIND_APPEND, '1, 7'd0);
    add_field(KIND_APPEND, '1, 7'd64);
    add_field(KIND_APPEND, '0, 7'd64);
    add_field(KIND_APPEND, 64'h1, 7'd1);
    add_field(KIND_FINISH, '1, 7'd127);
    add_field(KIND_FINISH, '0, 7'd0);
    add_field(KIND_APPEND, 64'h5, 7'd3);
    add_field(KIND_APPEND, 64'h1b, 7'd5);
    add_field(KIND_APPEND, 64'hffff_ffff_ffff_ff55, 7'd7);
    add_field(KIND_APPEND, 64'h0123_4567_89ab_cdef, 7'd64);
    add_field(KIND_FINISH, 64'h0, 7'd5);
    add_field(KIND_APPEND, '1, 7'd127);
    add_field(KIND_APPEND, 64'haaaa_aaaa_aaaa_aaaa, 7'd65);
    add_field(KIND_APPEND, 64'hffff_ffff_ffff_ffa5, 7'd8);
    add_field(KIND_APPEND, 64'h1234, 7'd16);
    add_field(KIND_APPEND, 64'hdead_beef, 7'd32);
    add_field(KIND_APPEND, 64'h3, 7'd2);
    add_field(KIND_APPEND, '0, 7'd0);
    add_field(KIND_FINISH, '1, 7'd64);
    add_field(KIND_APPEND, 64'h7f, 7'd7);
    add_field(KIND_FINISH, 64'h0, 7'd0);

    // random runs of appends closed by a finish
    made = 0;
    while (made < RAND_FIELDS) begin
      run_len = $urandom_range(1, 16);
      for (j = 0; j < run_len; j++) begin
        r = $urandom_range(0, 9);
        case (r)
          0: bc = 7'd0;
          1: bc = BC_W'($urandom_range(65, 127));
          2: bc = 7'd8 << $urandom_range(0, 3);
          3, 4, 5: bc = BC_W'($urandom_range(1, 7));
          default: bc = BC_W'($urandom_range(1, 64));
        endcase
        add_field(KIND_APPEND, rand_value(), bc);
        made++;
      end
      add_field(KIND_FINISH, rand_value(), BC_W'($urandom_range(0, 127)));
      made++;
      if ($urandom_range(0, 5) == 0) begin
        add_field(KIND_FINISH, rand_value(), BC_W'($urandom_range(0, 127)));
        made++;
      end
    end

    // ragged tail, then flush twice
    for (j = 0; j < 5; j++) add_field(KIND_APPEND, rand_value(), BC_W'($urandom_range(1, 64)));
    add_field(KIND_FINISH, rand_value(), BC_W'($urandom_range(0, 127)));
    add_field(KIND_APPEND, 64'h6, 7'd3);
    add_field(KIND_FINISH, rand_value(), BC_W'($urandom_range(0, 127)));
    total_fields = fields_pending.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (fields_taken < total_fields) @(posedge clk_i);
    while (byte_beats_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mfbp_pkg.sv
design/mfbp_front.sv
design/mfbp_fifo.sv
design/mfbp_back.sv
design/msb_first_bit_packer_core.sv
design/mfbp_checker.sv
tb/tb_top.sv
